[hdl/e2h_pkg.sv]
package e2h_pkg;

    typedef logic [63:0] t_turn;
    typedef logic signed [33:0] t_q30;
    typedef logic signed [41:0] t_vec;

    typedef enum logic [0:0] {
        CFG_LATITUDE  = 1'b0,
        CFG_LONGITUDE = 1'b1
    } t_cfg_index;

    localparam t_turn HALF_TURN    = 64'h8000_0000_0000_0000;
    localparam t_turn QUARTER_TURN = 64'h4000_0000_0000_0000;
    localparam t_turn EPOCH_DAYS   = 64'd2451545;
    localparam t_turn PHASE0       = 64'd14371070138404760294;
    localparam t_turn RATE_EXCESS  = 64'd50505513091326348;
    localparam t_turn INV_PI_Q64   = 64'h517C_C1B7_2722_0A95;
    localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;

    // shift-subtract divide, elaboration only
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] val);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bitv;
        v = val;
        res = '0;
        for (int k = 31; k >= 0; k--) begin
            bitv = 64'd1 << (2 * k);
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
        end
        return res;
    endfunction

    // atan(2^-i) as a fraction of a turn, 2^64 per turn
    function automatic t_turn atan_turn(input int i);
        logic [63:0] acc;
        logic [63:0] term;
        logic [127:0] prod;
        int m;
        acc = '0;
        if (i == 0) begin
            return 64'd1 << 61;
        end
        for (int k = 0; k < 32; k++) begin
            m = i * (2 * k + 1);
            if (m <= 63) begin
                term = udiv64(64'd1 << (63 - m), 64'(2 * k + 1));
                acc = k[0] ? acc - term : acc + term;
            end
        end
        prod = {64'd0, acc} * {64'd0, INV_PI_Q64};
        return prod[127:64];
    endfunction

    // Q30 inverse of the rotation gain for a given stage count
    function automatic t_turn gain_inv(input int n);
        logic [63:0] g;
        g = 64'd1 << 60;
        for (int i = 0; i < 64; i++) begin
            if (i < n && 2 * i < 64) begin
                g = g + (g >> (2 * i));
            end
        end
        return udiv64(64'd1 << 60, isqrt64(g));
    endfunction

endpackage

[hdl/e2h_in_if.sv]
interface e2h_in_if #(parameter int ANGLE_BITS = 32);
    logic                         valid;
    logic                         ready;
    logic [47:0]                  julian_date;
    logic [ANGLE_BITS-1:0]        obj_ra;
    logic signed [ANGLE_BITS-1:0] declination;
    logic [31:0]                  distance_in;

    modport source (output valid, julian_date, obj_ra, declination, distance_in,
                    input ready);
    modport sink (input valid, julian_date, obj_ra, declination, distance_in,
                  output ready);
endinterface

[hdl/e2h_out_if.sv]
interface e2h_out_if #(parameter int ANGLE_BITS = 32);
    logic                         valid;
    logic                         ready;
    logic signed [ANGLE_BITS-1:0] altitude;
    logic [ANGLE_BITS-1:0]        azimuth;
    logic [31:0]                  distance_out;

    modport source (output valid, altitude, azimuth, distance_out, input ready);
    modport sink (input valid, altitude, azimuth, distance_out, output ready);
endinterface

[hdl/e2h_sincos.sv]
module e2h_sincos import e2h_pkg::*; #(
    parameter int STAGES = 24
) (
    input  logic  i_clk,
    input  logic  i_en,
    input  t_turn i_angle,
    output t_q30  o_sin,
    output t_q30  o_cos
);

    localparam t_turn GAIN_WIDE = gain_inv(STAGES);
    localparam t_q30  GAIN = GAIN_WIDE[33:0];

    t_q30  r_x [0:STAGES];
    t_q30  r_y [0:STAGES];
    t_turn r_a [0:STAGES];
    logic  r_f [0:STAGES];
    t_q30  r_sin;
    t_q30  r_cos;

    t_turn n_biased;
    assign n_biased = i_angle + QUARTER_TURN;

    // fold the left half plane onto the right, undo with a sign flip at the end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f[0] <= n_biased[63];
            r_a[0] <= n_biased[63] ? i_angle + HALF_TURN : i_angle;
            r_x[0] <= GAIN;
            r_y[0] <= '0;
        end
    end

    for (genvar j = 1; j <= STAGES; j++) begin : g_stage
        localparam t_turn ANG = atan_turn(j - 1);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_f[j] <= r_f[j-1];
                if (!r_a[j-1][63]) begin
                    r_x[j] <= r_x[j-1] - (r_y[j-1] >>> (j - 1));
                    r_y[j] <= r_y[j-1] + (r_x[j-1] >>> (j - 1));
                    r_a[j] <= r_a[j-1] - ANG;
                end else begin
                    r_x[j] <= r_x[j-1] + (r_y[j-1] >>> (j - 1));
                    r_y[j] <= r_y[j-1] - (r_x[j-1] >>> (j - 1));
                    r_a[j] <= r_a[j-1] + ANG;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sin <= r_f[STAGES] ? -r_y[STAGES] : r_y[STAGES];
            r_cos <= r_f[STAGES] ? -r_x[STAGES] : r_x[STAGES];
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

[hdl/equatorial_to_horizontal.sv]
// Throughput: one beat per cycle; the whole pipeline advances whenever the output
// register is empty or taken, so a downstream stall holds every stage in place.
// Depth is set by the three sine/cosine pipelines, the 31-step square root and
// the two arctangent pipelines. Synchronous active-low reset clears valid bits and
// both observer registers (latitude and longitude reset to zero).
module equatorial_to_horizontal import e2h_pkg::*; #(
    parameter int ANGLE_BITS         = 32,
    parameter int DATE_FRACTION_BITS = 24,
    parameter int CORDIC_STAGES      = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  t_cfg_index            i_cfg_index,
    input  logic [ANGLE_BITS-1:0] i_cfg_data,
    e2h_in_if.sink                i_in,
    e2h_out_if.source             o_out
);

    localparam int N        = CORDIC_STAGES;
    localparam int AB       = ANGLE_BITS;
    localparam int F        = DATE_FRACTION_BITS;
    localparam int LOWB     = 64 - AB;
    localparam int ISQ      = 31;
    localparam int PIPE_LEN = 2 * N + 44;
    localparam t_turn EPOCH_FX = EPOCH_DAYS << F;
    localparam t_turn RND      = 64'd1 << (63 - AB);
    localparam logic signed [28:0] EH = {1'b0, RATE_EXCESS[55:28]};
    localparam logic signed [28:0] EL = {1'b0, RATE_EXCESS[27:0]};

    logic en;
    logic [AB-1:0] r_lat;
    logic [AB-1:0] r_lon;
    logic r_vpipe [0:PIPE_LEN-1];
    logic [31:0] r_dist [0:PIPE_LEN-1];
    logic r_out_valid;
    logic signed [AB-1:0] r_alt;
    logic [AB-1:0] r_azi;
    logic [31:0] r_dist_out;

    assign en = ~r_out_valid | o_out.ready;
    assign i_in.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lat <= '0;
            r_lon <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LATITUDE:  r_lat <= i_cfg_data;
                CFG_LONGITUDE: r_lon <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // valid bits and pass-through distance travel the full depth
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < PIPE_LEN; j++) begin
                r_vpipe[j] <= 1'b0;
            end
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_vpipe[0] <= i_in.valid;
            for (int j = 1; j < PIPE_LEN; j++) begin
                r_vpipe[j] <= r_vpipe[j-1];
            end
            r_out_valid <= r_vpipe[PIPE_LEN-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dist[0] <= i_in.distance_in;
            for (int j = 1; j < PIPE_LEN; j++) begin
                r_dist[j] <= r_dist[j-1];
            end
        end
    end

    // ---------------- sidereal time and hour angle ----------------
    t_turn r_d1, r_d2, r_d3, r_d4;
    logic [AB-1:0] r_ra1, r_ra2, r_ra3, r_ra4, r_ra5;
    logic [AB-1:0] r_dec1, r_dec2, r_dec3, r_dec4, r_dec5, r_dec6;
    logic signed [60:0] r_pp_hh, r_pp_hl;
    logic signed [61:0] r_pp_lh, r_pp_ll;
    logic signed [95:0] r_part_a3, r_part_b3, r_prod4;
    t_turn r_phase5, r_ha6;

    logic signed [31:0] dh;
    logic signed [32:0] dl;
    assign dh = r_d1[63:32];
    assign dl = {1'b0, r_d1[31:0]};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d1   <= {16'd0, i_in.julian_date} - EPOCH_FX;
            r_ra1  <= i_in.obj_ra;
            r_dec1 <= i_in.declination;

            r_pp_hh <= 61'(dh) * 61'(EH);
            r_pp_hl <= 61'(dh) * 61'(EL);
            r_pp_lh <= 62'(dl) * 62'(EH);
            r_pp_ll <= 62'(dl) * 62'(EL);
            r_d2    <= r_d1;
            r_ra2   <= r_ra1;
            r_dec2  <= r_dec1;

            r_part_a3 <= (96'(r_pp_hh) <<< 60) + (96'(r_pp_hl) <<< 32);
            r_part_b3 <= (96'(r_pp_lh) <<< 28) + 96'(r_pp_ll);
            r_d3      <= r_d2;
            r_ra3     <= r_ra2;
            r_dec3    <= r_dec2;

            r_prod4 <= r_part_a3 + r_part_b3;
            r_d4    <= r_d3;
            r_ra4   <= r_ra3;
            r_dec4  <= r_dec3;

            // signed day offset times rate excess, scaled back by the date fraction
            r_phase5 <= PHASE0 + (r_d4 << (64 - F)) + r_prod4[63+F:F];
            r_ra5    <= r_ra4;
            r_dec5   <= r_dec4;

            r_ha6  <= r_phase5 + {r_lon, {LOWB{1'b0}}} - {r_ra5, {LOWB{1'b0}}};
            r_dec6 <= r_dec5;
        end
    end

    // ---------------- sines and cosines ----------------
    t_q30 sd, cd, sl, cl, sh, ch;

    e2h_sincos #(.STAGES(N)) u_dec (
        .i_clk(i_clk), .i_en(en), .i_angle({r_dec6, {LOWB{1'b0}}}), .o_sin(sd), .o_cos(cd)
    );
    e2h_sincos #(.STAGES(N)) u_lat (
        .i_clk(i_clk), .i_en(en), .i_angle({r_lat, {LOWB{1'b0}}}), .o_sin(sl), .o_cos(cl)
    );
    e2h_sincos #(.STAGES(N)) u_ha (
        .i_clk(i_clk), .i_en(en), .i_angle(r_ha6), .o_sin(sh), .o_cos(ch)
    );

    // ---------------- products ----------------
    logic signed [67:0] m_sdsl, m_cdcl, m_shcd, m_chsl, m_sdcl;
    logic signed [67:0] r_sdsl1, r_sdcl1, r_sdsl2, r_sdcl2;
    logic signed [37:0] r_cdcl1, r_yv1, r_t1, r_yv2;
    t_q30 r_cd1, r_ch1;
    logic signed [71:0] m_p3, m_p5, r_p3, r_p5;
    logic signed [72:0] m_sum, m_xs;
    logic signed [42:0] m_sa_raw;
    logic signed [31:0] r_sa3, r_sa4;
    t_vec r_yv3, r_xv3, r_yv4, r_xv4;
    logic signed [63:0] m_sq;
    logic [63:0] m_v;
    logic [61:0] r_v4;

    assign m_sdsl = 68'(sd) * 68'(sl);
    assign m_cdcl = 68'(cd) * 68'(cl);
    assign m_shcd = 68'(sh) * 68'(cd);
    assign m_chsl = 68'(ch) * 68'(sl);
    assign m_sdcl = 68'(sd) * 68'(cl);
    assign m_p3 = 72'(r_cdcl1) * 72'(r_ch1);
    assign m_p5 = 72'(r_t1) * 72'(r_cd1);
    assign m_sum = 73'(r_sdsl2) + 73'(r_p3);
    assign m_xs = 73'(r_p5) - 73'(r_sdcl2);
    assign m_sa_raw = m_sum[72:30];
    assign m_sq = 64'(r_sa3) * 64'(r_sa3);
    assign m_v = (64'd1 << 60) - m_sq;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sdsl1 <= m_sdsl;
            r_sdcl1 <= m_sdcl;
            r_cdcl1 <= m_cdcl[67:30];
            r_yv1   <= m_shcd[67:30];
            r_t1    <= m_chsl[67:30];
            r_cd1   <= cd;
            r_ch1   <= ch;

            r_p3    <= m_p3;
            r_p5    <= m_p5;
            r_sdsl2 <= r_sdsl1;
            r_sdcl2 <= r_sdcl1;
            r_yv2   <= r_yv1;

            // sine of altitude clamped to plus or minus one
            if (m_sa_raw > 43'(ONE_Q30)) begin
                r_sa3 <= ONE_Q30;
            end else if (m_sa_raw < -43'(ONE_Q30)) begin
                r_sa3 <= -ONE_Q30;
            end else begin
                r_sa3 <= m_sa_raw[31:0];
            end
            r_xv3 <= m_xs[71:30];
            r_yv3 <= 42'(r_yv2);

            r_v4  <= {1'b0, m_v[60:0]};
            r_sa4 <= r_sa3;
            r_yv4 <= r_yv3;
            r_xv4 <= r_xv3;
        end
    end

    // ---------------- cosine of altitude: digit-per-stage square root ----------------
    logic [61:0] r_rem [0:ISQ-1];
    logic [61:0] r_res [0:ISQ-1];
    logic signed [31:0] r_q_sa [0:ISQ-1];
    t_vec r_q_yv [0:ISQ-1];
    t_vec r_q_xv [0:ISQ-1];

    for (genvar q = 0; q < ISQ; q++) begin : g_sqrt
        localparam logic [61:0] BITV = 62'd1 << (2 * (ISQ - 1 - q));
        logic [61:0] rem_in, res_in;
        if (q == 0) begin : g_first
            assign rem_in = r_v4;
            assign res_in = '0;
        end else begin : g_next
            assign rem_in = r_rem[q-1];
            assign res_in = r_res[q-1];
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                if (rem_in >= res_in + BITV) begin
                    r_rem[q] <= rem_in - (res_in + BITV);
                    r_res[q] <= (res_in >> 1) + BITV;
                end else begin
                    r_rem[q] <= rem_in;
                    r_res[q] <= res_in >> 1;
                end
                if (q == 0) begin
                    r_q_sa[q] <= r_sa4;
                    r_q_yv[q] <= r_yv4;
                    r_q_xv[q] <= r_xv4;
                end else begin
                    r_q_sa[q] <= r_q_sa[q-1];
                    r_q_yv[q] <= r_q_yv[q-1];
                    r_q_xv[q] <= r_q_xv[q-1];
                end
            end
        end
    end

    // ---------------- arctangents: lane 0 altitude, lane 1 azimuth ----------------
    t_vec  lane_y [0:1];
    t_vec  lane_x [0:1];
    t_turn lane_z [0:1];
    logic  lane_zero [0:1];

    assign lane_y[0] = 42'(r_q_sa[ISQ-1]);
    assign lane_x[0] = {1'b0, r_res[ISQ-1][40:0]};
    assign lane_y[1] = r_q_yv[ISQ-1];
    assign lane_x[1] = r_q_xv[ISQ-1];

    for (genvar l = 0; l < 2; l++) begin : g_lane
        t_vec  r_x [0:N];
        t_vec  r_y [0:N];
        t_turn r_z [0:N];
        logic  r_zero [0:N];

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_zero[0] <= (lane_x[l] == '0) && (lane_y[l] == '0);
                if (lane_x[l] < 0) begin
                    r_x[0] <= -lane_x[l];
                    r_y[0] <= -lane_y[l];
                    r_z[0] <= HALF_TURN;
                end else begin
                    r_x[0] <= lane_x[l];
                    r_y[0] <= lane_y[l];
                    r_z[0] <= '0;
                end
            end
        end

        for (genvar j = 1; j <= N; j++) begin : g_stage
            localparam t_turn ANG = atan_turn(j - 1);
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_zero[j] <= r_zero[j-1];
                    if (r_y[j-1] >= 0) begin
                        r_x[j] <= r_x[j-1] + (r_y[j-1] >>> (j - 1));
                        r_y[j] <= r_y[j-1] - (r_x[j-1] >>> (j - 1));
                        r_z[j] <= r_z[j-1] + ANG;
                    end else begin
                        r_x[j] <= r_x[j-1] - (r_y[j-1] >>> (j - 1));
                        r_y[j] <= r_y[j-1] + (r_x[j-1] >>> (j - 1));
                        r_z[j] <= r_z[j-1] - ANG;
                    end
                end
            end
        end

        assign lane_z[l]    = r_z[N];
        assign lane_zero[l] = r_zero[N];
    end

    // round to field width; a zero vector gives altitude zero and azimuth half a turn
    t_turn m_alt_turn, m_azi_turn, m_alt_rnd, m_azi_rnd;
    assign m_alt_turn = lane_zero[0] ? '0 : lane_z[0];
    assign m_azi_turn = (lane_zero[1] ? '0 : lane_z[1]) + HALF_TURN;
    assign m_alt_rnd  = m_alt_turn + RND;
    assign m_azi_rnd  = m_azi_turn + RND;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_alt      <= m_alt_rnd[63:LOWB];
            r_azi      <= m_azi_rnd[63:LOWB];
            r_dist_out <= r_dist[PIPE_LEN-1];
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.altitude     = r_alt;
    assign o_out.azimuth      = r_azi;
    assign o_out.distance_out = r_dist_out;

endmodule

[verif/tb_equatorial_to_horizontal.sv]
module tb_equatorial_to_horizontal import e2h_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DATE_FRAC = 24;
    localparam int STAGES    = 24;
    localparam int LATENCY   = 2 * STAGES + 45;

    typedef struct {
        logic [47:0]        jd;
        logic [31:0]        ra;
        logic signed [31:0] dec;
        logic [31:0]        dist_au;
    } t_sky_item;

    typedef struct {
        logic signed [31:0] alt;
        logic [31:0]        az;
        logic [31:0]        dist_au;
    } t_horiz_pos;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we;
    t_cfg_index i_cfg_index;
    logic [31:0] i_cfg_data;

    e2h_in_if #(.ANGLE_BITS(32)) in_bus();
    e2h_out_if #(.ANGLE_BITS(32)) out_bus();

    equatorial_to_horizontal u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_bus.sink),
        .o_out       (out_bus.source)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // observer setting as seen by the predictor
    logic [31:0] obs_lat = '0;
    logic [31:0] obs_lon = '0;

    logic [63:0] atan_tab [0:STAGES-1];
    longint      gain_q30;

    t_sky_item  pending_items[$];
    t_horiz_pos expected_pos[$];
    int n_sent = 0;
    int n_got = 0;
    int n_bad = 0;
    int n_phases = 0;

    function automatic logic [63:0] root64(input logic [63:0] val);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] b;
        v = val;
        res = '0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    task automatic build_tables();
        logic [63:0] acc;
        logic [63:0] term;
        logic [127:0] prod;
        logic [63:0] g;
        int k;
        atan_tab[0] = 64'd1 << 61;
        for (int i = 1; i < STAGES; i++) begin
            acc = '0;
            k = 0;
            while (i * (2 * k + 1) <= 63) begin
                term = (64'd1 << (63 - i * (2 * k + 1))) / 64'(2 * k + 1);
                acc = k[0] ? acc - term : acc + term;
                k++;
            end
            prod = {64'd0, acc} * {64'd0, INV_PI_Q64};
            atan_tab[i] = prod[127:64];
        end
        g = 64'd1 << 60;
        for (int i = 0; i < STAGES; i++) g = g + (g >> (2 * i));
        gain_q30 = longint'((64'd1 << 60) / root64(g));
    endtask

    task automatic rotate(input logic [63:0] ang, output longint s, output longint c);
        logic [63:0] a;
        logic [63:0] probe;
        logic flip;
        longint x;
        longint y;
        longint nx;
        a = ang;
        probe = a + QUARTER_TURN;
        flip = probe[63];
        x = gain_q30;
        y = 0;
        if (flip) a = a + HALF_TURN;
        for (int i = 0; i < STAGES; i++) begin
            if (!a[63]) begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                a = a - atan_tab[i];
            end else begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                a = a + atan_tab[i];
            end
            x = nx;
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endtask

    function automatic logic [63:0] vector_angle(input longint yin, input longint xin);
        longint x;
        longint y;
        longint nx;
        logic [63:0] z;
        x = xin;
        y = yin;
        z = '0;
        if (x == 0 && y == 0) return '0;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = HALF_TURN;
        end
        for (int i = 0; i < STAGES; i++) begin
            if (y >= 0) begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z = z + atan_tab[i];
            end else begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z = z - atan_tab[i];
            end
            x = nx;
        end
        return z;
    endfunction

    function automatic logic [31:0] round_angle(input logic [63:0] t);
        logic [63:0] r;
        r = t + (64'd1 << 31);
        return r[63:32];
    endfunction

    task automatic predict_position(input t_sky_item it, output t_horiz_pos p);
        logic [63:0] d;
        logic [127:0] prod;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [63:0] phase;
        logic [63:0] ha;
        longint sd, cd, sl, cl, sh, ch, sa, ca, yv, xv, t;
        d = {16'd0, it.jd} - (EPOCH_DAYS << DATE_FRAC);
        prod = {64'd0, d} * {64'd0, RATE_EXCESS};
        hi = prod[127:64];
        lo = prod[63:0];
        if (d[63]) hi = hi - RATE_EXCESS;
        phase = PHASE0 + (d << (64 - DATE_FRAC))
              + ((lo >> DATE_FRAC) | (hi << (64 - DATE_FRAC)));
        ha = phase + {obs_lon, 32'd0} - {it.ra, 32'd0};
        rotate({it.dec, 32'd0}, sd, cd);
        rotate({obs_lat, 32'd0}, sl, cl);
        rotate(ha, sh, ch);
        sa = (sd * sl + ((cd * cl) >>> 30) * ch) >>> 30;
        if (sa > ONE_Q30) sa = ONE_Q30;
        if (sa < -ONE_Q30) sa = -ONE_Q30;
        ca = longint'(root64(64'((longint'(ONE_Q30) * ONE_Q30) - sa * sa)));
        yv = (sh * cd) >>> 30;
        t = (ch * sl) >>> 30;
        xv = (t * cd - sd * cl) >>> 30;
        p.alt = round_angle(vector_angle(sa, ca));
        p.az = round_angle(vector_angle(yv, xv) + HALF_TURN);
        p.dist_au = it.dist_au;
    endtask

    // sender: bursts and gaps
    t_sky_item cur_item;
    int burst_left = 1;
    int gap_left = 0;

    always @(posedge i_clk) begin
        t_horiz_pos p;
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
        end else begin
            if (in_bus.valid && in_bus.ready) begin
                predict_position(cur_item, p);
                expected_pos.push_back(p);
                n_sent++;
            end
            if (!in_bus.valid || in_bus.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_bus.valid <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    cur_item = pending_items.pop_front();
                    in_bus.julian_date <= cur_item.jd;
                    in_bus.obj_ra <= cur_item.ra;
                    in_bus.declination <= cur_item.dec;
                    in_bus.distance_in <= cur_item.dist_au;
                    in_bus.valid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(40, 1);
                        gap_left = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
                    end
                end else begin
                    in_bus.valid <= 1'b0;
                end
            end
        end
    end

    // receiver: stall pattern changes now and then; one long hold-off
    int stall_mode = 0;
    int mode_left = 0;
    int hold_left = 0;
    bit did_hold = 1'b0;
    int cyc = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_bus.ready <= 1'b0;
        end else begin
            cyc++;
            if (mode_left == 0) begin
                stall_mode = $urandom_range(2, 0);
                mode_left = $urandom_range(300, 50);
            end else begin
                mode_left--;
            end
            if (!did_hold && n_got >= 300) begin
                did_hold = 1'b1;
                hold_left = 500;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_bus.ready <= 1'b0;
            end else begin
                case (stall_mode)
                    0: out_bus.ready <= 1'b1;
                    1: out_bus.ready <= ($urandom_range(9, 0) >= 3);
                    default: out_bus.ready <= (cyc % 7 < 4);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        t_horiz_pos e;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            n_got++;
            if (expected_pos.size() == 0) begin
                n_bad++;
                if (n_bad <= 10) $display("unexpected beat: alt %h az %h dist %h",
                                          out_bus.altitude, out_bus.azimuth,
                                          out_bus.distance_out);
            end else begin
                e = expected_pos.pop_front();
                if (out_bus.altitude !== e.alt || out_bus.azimuth !== e.az
                        || out_bus.distance_out !== e.dist_au) begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("beat %0d mismatch: alt %h/%h az %h/%h dist %h/%h (exp/act)",
                                 n_got, e.alt, out_bus.altitude, e.az, out_bus.azimuth,
                                 e.dist_au, out_bus.distance_out);
                end
            end
        end
    end

    function automatic t_sky_item rand_item();
        t_sky_item it;
        logic [47:0] off;
        off = 48'({$urandom, $urandom});
        case ($urandom_range(3, 0))
            0: it.jd = off;
            default: it.jd = (48'd2451545 << DATE_FRAC) + {{8{off[40]}}, off[39:0]};
        endcase
        it.ra = $urandom;
        it.dec = $signed($urandom_range(32'h8000_0000, 0)) - 32'sh4000_0000;
        it.dist_au = $urandom;
        return it;
    endfunction

    function automatic t_sky_item mk(input logic [47:0] jd, input logic [31:0] ra,
                                     input logic [31:0] dec, input logic [31:0] dist_au);
        t_sky_item it;
        it.jd = jd;
        it.ra = ra;
        it.dec = dec;
        it.dist_au = dist_au;
        return it;
    endfunction

    task automatic write_reg(input t_cfg_index idx, input logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        if (idx == CFG_LATITUDE) obs_lat = val;
        else obs_lon = val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        @(negedge i_clk);
        while (pending_items.size() != 0 || in_bus.valid || expected_pos.size() != 0)
            @(negedge i_clk);
        repeat (LATENCY + 10) @(negedge i_clk);
    endtask

    initial begin
        logic [31:0] lat_set [0:5];
        logic [31:0] lon_set [0:5];
        logic [47:0] epoch;
        in_bus.valid = 1'b0;
        in_bus.julian_date = '0;
        in_bus.obj_ra = '0;
        in_bus.declination = '0;
        in_bus.distance_in = '0;
        out_bus.ready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_LATITUDE;
        i_cfg_data = '0;
        build_tables();
        epoch = 48'd2451545 << DATE_FRAC;
        lat_set = '{32'h0, 32'h4000_0000, 32'hC000_0000, $urandom_range(32'h8000_0000, 0)
                    - 32'h4000_0000, 32'h4000_0000, 32'h1234_5678};
        lon_set = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, $urandom, $urandom, 32'hFFFF_FFFF};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int ph = 0; ph < 6; ph++) begin
            if (ph != 0) begin
                write_reg(CFG_LATITUDE, lat_set[ph]);
                write_reg(CFG_LONGITUDE, lon_set[ph]);
            end
            @(negedge i_clk);
            if (ph == 0) begin
                // field extremes, epoch edges, poles
                pending_items.push_back(mk('0, '0, '0, '0));
                pending_items.push_back(mk('1, '1, 32'h4000_0000, '1));
                pending_items.push_back(mk(epoch, 32'h8000_0000, 32'hC000_0000, 32'h0100_0000));
                pending_items.push_back(mk(epoch - 1, 32'h4000_0000, 32'h2000_0000, 32'h5555_5555));
                pending_items.push_back(mk(epoch + 1, 32'hC000_0000, 32'hE000_0000, 32'hAAAA_AAAA));
                pending_items.push_back(mk(48'h8000_0000_0000, 32'h0000_0001, 32'h3FFF_FFFF, 1));
                pending_items.push_back(mk(48'h7FFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hC000_0001, 2));
                for (int k = 0; k < 8; k++)
                    pending_items.push_back(mk(48'(epoch + {$urandom, $urandom} % 48'h1_0000_0000),
                                               $urandom, 32'h4000_0000 * k, $urandom));
            end
            if (lat_set[ph] == 32'h4000_0000 || lat_set[ph] == 32'hC000_0000) begin
                // object at a pole seen from a pole
                pending_items.push_back(mk(epoch, $urandom, 32'h4000_0000, 7));
                pending_items.push_back(mk(48'($urandom), $urandom, 32'hC000_0000, 9));
            end
            for (int k = 0; k < 250; k++) pending_items.push_back(rand_item());
            drain();
            n_phases++;
        end

        if (expected_pos.size() != 0) n_bad++;
        $display("%0d positions sent, %0d checked over %0d observer settings, %0d errors",
                 n_sent, n_got, n_phases, n_bad);
        $display("covered poles, dates around and far from the epoch, long output hold-off");
        if (n_bad == 0) begin
            $display("** equatorial_to_horizontal: PASSED **");
        end else begin
            $display("** equatorial_to_horizontal: FAILED **");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("timeout: %0d sent, %0d received", n_sent, n_got);
        $display("** equatorial_to_horizontal: FAILED **");
        $finish;
    end

endmodule
